// File: design/wcd_pkg.sv
package wcd_pkg;

	localparam int DICT_DEPTH = 1024;
	localparam int MAX_WORD_LEN = 32;
	localparam int IDX_W = $clog2(DICT_DEPTH);
	localparam int POS_W = $clog2(MAX_WORD_LEN);
	localparam int LEN_W = POS_W + 1;
	localparam int DADDR_W = IDX_W + POS_W;
	localparam int WCNT_W = IDX_W + 1;
	localparam int CNT_W = 32;
	localparam int CFG_ADDR_W = 3;

	localparam logic [7:0] CHAR_A = 8'h61;
	localparam logic [7:0] CHAR_Z = 8'h7a;

	typedef enum logic [1:0] {
		CMD_LOAD = 2'd0,
		CMD_TEXT = 2'd1,
		CMD_READ = 2'd2,
		CMD_NONE = 2'd3
	} command_t;

	typedef enum logic [1:0] {
		KIND_FOUND = 2'd0,
		KIND_MISS = 2'd1,
		KIND_LONG = 2'd2,
		KIND_COUNT = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_CMP,
		ST_HIT,
		ST_CREAD
	} state_t;

	typedef struct packed {
		logic [1:0] command;
		logic [9:0] entry_index;
		logic [4:0] char_position;
		logic [7:0] byte_value;
	} request_t;

	typedef struct packed {
		logic [1:0] result_kind;
		logic [9:0] found_index;
		logic [31:0] hit_count;
	} result_t;

	typedef struct packed {
		logic we;
		logic [IDX_W-1:0] waddr;
		logic [CNT_W-1:0] wdata;
		logic re;
		logic [IDX_W-1:0] raddr;
	} cnt_port_t;

endpackage

// File: design/wcd_dict_ram.sv
module wcd_dict_ram import wcd_pkg::*; (
	input logic clk,
	input logic we,
	input logic [DADDR_W-1:0] waddr,
	input logic [7:0] wdata,
	input logic re,
	input logic [DADDR_W-1:0] raddr,
	output logic [7:0] rdata
);

	logic [7:0] mem [DICT_DEPTH*MAX_WORD_LEN];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// File: design/wcd_count_ram.sv
module wcd_count_ram import wcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input cnt_port_t port,
	output logic [CNT_W-1:0] rdata,
	output logic clearing
);

	logic [CNT_W-1:0] mem [DICT_DEPTH];
	logic [IDX_W:0] clr_q;

	assign clearing = !clr_q[IDX_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= '0;
		end else if (clearing) begin
			clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (clearing) begin
			mem[clr_q[IDX_W-1:0]] <= '0;
		end else if (port.we) begin
			mem[port.waddr] <= port.wdata;
		end
		if (port.re) begin
			rdata <= mem[port.raddr];
		end
	end

endmodule

// File: design/word_tokenize_dictionary_count_top.sv
// Dictionary word counter.
// Requests enter on start when busy is low. A load request writes one
// dictionary character; a text request adds a letter to the current word or,
// on any other byte, ends the word and binary searches the first word_count
// (at most 1024) sorted entries. Each result is shown for one cycle on result
// while done is high; the receiver cannot stall, so no result is ever held
// back. Loads and letters never leave the idle state. A count read reads the
// counter memory and registers the value in ST_CREAD. A word end starts each
// search probe in ST_SEARCH and then compares in ST_CMP one character at a
// time (at most 33 per probe), since the dictionary memory gives one character
// per cycle; a hit adds a read-modify-write on the counter memory in ST_HIT.
// An overlong word answers from the idle state without a search.
// After reset the counter memory is swept to zero, one entry a cycle, and
// busy stays high until all 1024 entries are clear. word_count resets to zero
// and is written through the APB port at addresses 0 to 3 (paddr[2] low).
module word_tokenize_dictionary_count_top import wcd_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input request_t request,
	output logic done,
	output result_t result,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [CFG_ADDR_W-1:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	state_t state_q, state_d;
	logic [WCNT_W-1:0] word_count_q;
	logic [7:0] word_q [MAX_WORD_LEN];
	logic [LEN_W-1:0] len_q;
	logic overlong_q;
	logic [WCNT_W-1:0] low_q, hi_q;
	logic [IDX_W-1:0] mid_q;
	logic [LEN_W-1:0] ci_q;
	logic [IDX_W-1:0] cport_idx_q;
	logic done_q;
	result_t result_q;

	logic clearing, accept, is_letter;
	logic dict_we, dict_re;
	logic [DADDR_W-1:0] dict_raddr;
	logic [7:0] dict_rdata, wc, ec;
	logic [CNT_W-1:0] cnt_rdata, cnt_inc;
	cnt_port_t cport;
	logic [WCNT_W-1:0] n_eff, mid_sum;

	assign pready = 1'b1;
	assign prdata = (paddr[CFG_ADDR_W-1] == 1'b0) ? {{(32-WCNT_W){1'b0}}, word_count_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
		end else if (psel && penable && pwrite && pready && paddr[CFG_ADDR_W-1] == 1'b0) begin
			word_count_q <= pwdata[WCNT_W-1:0];
		end
	end

	assign busy = clearing || state_q != ST_IDLE;
	assign accept = start && !busy;
	assign is_letter = request.byte_value >= CHAR_A && request.byte_value <= CHAR_Z;
	assign n_eff = (word_count_q > WCNT_W'(DICT_DEPTH)) ? WCNT_W'(DICT_DEPTH) : word_count_q;
	assign mid_sum = (low_q + hi_q - 1'b1) >> 1;
	assign wc = (ci_q < len_q) ? word_q[ci_q[POS_W-1:0]] : 8'd0;
	assign ec = ci_q[POS_W] ? 8'd0 : dict_rdata;
	assign cnt_inc = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + 1'b1;
	assign done = done_q;
	assign result = result_q;

	assign dict_we = accept && request.command == CMD_LOAD;

	wcd_dict_ram u_dict (
		.clk(clk),
		.we(dict_we),
		.waddr({request.entry_index, request.char_position}),
		.wdata(request.byte_value),
		.re(dict_re),
		.raddr(dict_raddr),
		.rdata(dict_rdata)
	);

	wcd_count_ram u_count (
		.clk(clk),
		.arst_n(arst_n),
		.port(cport),
		.rdata(cnt_rdata),
		.clearing(clearing)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		dict_re = 1'b0;
		dict_raddr = {mid_sum[IDX_W-1:0], {POS_W{1'b0}}};
		cport = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept && request.command == CMD_READ) begin
					cport.re = 1'b1;
					cport.raddr = request.entry_index;
					state_d = ST_CREAD;
				end else if (accept && request.command == CMD_TEXT && !is_letter
						&& len_q != '0 && !overlong_q) begin
					state_d = ST_SEARCH;
				end
			end
			ST_SEARCH: begin
				if (low_q < hi_q) begin
					dict_re = 1'b1;
					state_d = ST_CMP;
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_CMP: begin
				dict_raddr = {mid_q, ci_q[POS_W-1:0] + 1'b1};
				if (wc != ec) begin
					state_d = ST_SEARCH;
				end else if (wc == 8'd0) begin
					cport.re = 1'b1;
					cport.raddr = mid_q;
					state_d = ST_HIT;
				end else begin
					dict_re = 1'b1;
				end
			end
			ST_HIT: begin
				cport.we = 1'b1;
				cport.waddr = mid_q;
				cport.wdata = cnt_inc;
				state_d = ST_IDLE;
			end
			ST_CREAD: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (accept && request.command == CMD_TEXT && is_letter && !len_q[POS_W]) begin
			word_q[len_q[POS_W-1:0]] <= request.byte_value;
		end
		if (state_q == ST_SEARCH) begin
			mid_q <= mid_sum[IDX_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q <= '0;
			overlong_q <= 1'b0;
			low_q <= '0;
			hi_q <= '0;
			ci_q <= '0;
			done_q <= 1'b0;
			result_q <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept && request.command == CMD_TEXT) begin
						if (is_letter) begin
							if (!len_q[POS_W]) begin
								len_q <= len_q + 1'b1;
							end else begin
								overlong_q <= 1'b1;
							end
						end else if (len_q != '0) begin
							if (overlong_q) begin
								done_q <= 1'b1;
								result_q <= '{result_kind: KIND_LONG, found_index: '0,
									hit_count: '0};
								len_q <= '0;
								overlong_q <= 1'b0;
							end else begin
								low_q <= '0;
								hi_q <= n_eff;
							end
						end
					end
				end
				ST_SEARCH: begin
					ci_q <= '0;
					if (!(low_q < hi_q)) begin
						done_q <= 1'b1;
						result_q <= '{result_kind: KIND_MISS, found_index: '0, hit_count: '0};
						len_q <= '0;
					end
				end
				ST_CMP: begin
					if (wc != ec) begin
						if (wc < ec) begin
							hi_q <= {1'b0, mid_q};
						end else begin
							low_q <= {1'b0, mid_q} + 1'b1;
						end
					end else if (wc != 8'd0) begin
						ci_q <= ci_q + 1'b1;
					end
				end
				ST_HIT: begin
					done_q <= 1'b1;
					result_q <= '{result_kind: KIND_FOUND, found_index: mid_q,
						hit_count: cnt_inc};
					len_q <= '0;
				end
				ST_CREAD: begin
					done_q <= 1'b1;
					result_q <= '{result_kind: KIND_COUNT, found_index: cport_idx_q,
						hit_count: cnt_rdata};
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept && request.command == CMD_READ) begin
			cport_idx_q <= request.entry_index;
		end
	end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps

module tb;
	import wcd_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	request_t request = '0;
	logic done;
	result_t result;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [CFG_ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	word_tokenize_dictionary_count_top dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .request(request),
		.done(done), .result(result), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	logic [7:0] dict_chars [DICT_DEPTH][MAX_WORD_LEN];
	logic [31:0] entry_counts [DICT_DEPTH];
	logic [7:0] word_buf [MAX_WORD_LEN];
	int word_len;
	bit word_overlong;
	int word_count_reg;
	result_t pending_results[$];
	int error_count = 0;
	bit no_gaps = 1'b0;

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("MISMATCH %s: got %0d expected %0d at %0t", what, got, want, $realtime);
		error_count++;
	endtask

	function automatic int compare_with_entry(input int entry);
		int wc;
		int ec;
		for (int i = 0; i <= MAX_WORD_LEN; i++) begin
			wc = (i < word_len) ? word_buf[i] : 0;
			ec = (i < MAX_WORD_LEN) ? dict_chars[entry][i] : 0;
			if (wc != ec)
				return (wc < ec) ? -1 : 1;
			if (wc == 0)
				return 0;
		end
		return 0;
	endfunction

	function automatic int search_dictionary();
		int lo;
		int hi;
		int mid;
		int c;
		lo = 0;
		hi = ((word_count_reg > DICT_DEPTH) ? DICT_DEPTH : word_count_reg) - 1;
		while (lo <= hi) begin
			mid = (lo + hi) / 2;
			c = compare_with_entry(mid);
			if (c < 0)
				hi = mid - 1;
			else if (c > 0)
				lo = mid + 1;
			else
				return mid;
		end
		return -1;
	endfunction

	task automatic predict_request(input request_t r);
		result_t res;
		int hit;
		res = '0;
		case (command_t'(r.command))
			CMD_LOAD: begin
				dict_chars[r.entry_index][r.char_position] = r.byte_value;
				return;
			end
			CMD_READ: begin
				res.result_kind = KIND_COUNT;
				res.found_index = r.entry_index;
				res.hit_count = entry_counts[r.entry_index];
				pending_results.push_back(res);
				return;
			end
			CMD_NONE: return;
			default: ;
		endcase
		if (r.byte_value >= CHAR_A && r.byte_value <= CHAR_Z) begin
			if (word_len < MAX_WORD_LEN) begin
				word_buf[word_len] = r.byte_value;
				word_len++;
			end else
				word_overlong = 1'b1;
			return;
		end
		if (word_len == 0)
			return;
		if (word_overlong)
			res.result_kind = KIND_LONG;
		else begin
			hit = search_dictionary();
			if (hit < 0)
				res.result_kind = KIND_MISS;
			else begin
				if (entry_counts[hit] != 32'hFFFF_FFFF)
					entry_counts[hit]++;
				res.result_kind = KIND_FOUND;
				res.found_index = 10'(hit);
				res.hit_count = entry_counts[hit];
			end
		end
		pending_results.push_back(res);
		word_len = 0;
		word_overlong = 1'b0;
	endtask

	task automatic send_request(input command_t c, input int idx, input int pos, input int b);
		request_t r;
		int gap;
		r.command = c;
		r.entry_index = 10'(idx);
		r.char_position = 5'(pos);
		r.byte_value = 8'(b);
		gap = no_gaps ? 0 : $urandom_range(0, 16);
		@(negedge clk);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		start <= 1'b1;
		request <= r;
		do @(posedge clk); while (busy);
		predict_request(r);
	endtask

	task automatic quiesce();
		@(negedge clk);
		start <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (40) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic write_word_count(input int v);
		quiesce();
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b1;
		paddr <= '0;
		pwdata <= v;
		@(negedge clk);
		penable <= 1'b1;
		@(negedge clk);
		psel <= 1'b1;
		pwrite <= 1'b0;
		penable <= 1'b0;
		word_count_reg = v & 32'h7FF;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[WCNT_W-1:0] != word_count_reg[WCNT_W-1:0])
			report_mismatch("word_count readback", prdata, word_count_reg);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
	endtask

	function automatic int random_separator();
		int b;
		do b = $urandom_range(0, 255); while (b >= CHAR_A && b <= CHAR_Z);
		return b;
	endfunction

	task automatic send_word(input logic [7:0] letters[$]);
		foreach (letters[i])
			send_request(CMD_TEXT, 0, 0, letters[i]);
		send_request(CMD_TEXT, 0, 0, random_separator());
	endtask

	task automatic load_entry(input int idx, input logic [7:0] letters[$]);
		foreach (letters[i])
			send_request(CMD_LOAD, idx, i, letters[i]);
		if (letters.size() < MAX_WORD_LEN)
			send_request(CMD_LOAD, idx, letters.size(), 0);
	endtask

	function automatic void entry_letters(input int idx, ref logic [7:0] letters[$]);
		letters = {};
		for (int i = 0; i < MAX_WORD_LEN && dict_chars[idx][i] != 0; i++)
			letters.push_back(dict_chars[idx][i]);
	endfunction

	task automatic test_dictionary_load();
		logic [7:0] w[$];
		write_word_count(DICT_DEPTH);
		no_gaps = 1'b1;
		for (int i = 0; i < DICT_DEPTH - 1; i++) begin
			w = {8'(CHAR_A + i / 676), 8'(CHAR_A + (i / 26) % 26), 8'(CHAR_A + i % 26)};
			load_entry(i, w);
		end
		w = {};
		repeat (MAX_WORD_LEN) w.push_back(CHAR_Z);
		load_entry(DICT_DEPTH - 1, w);
		no_gaps = 1'b0;
	endtask

	task automatic test_directed_words();
		logic [7:0] w[$];
		w = {CHAR_A, CHAR_A, CHAR_A};
		send_word(w);
		send_word(w);
		send_request(CMD_TEXT, 0, 0, 8'h00);
		send_request(CMD_TEXT, 0, 0, 8'hFF);
		entry_letters(DICT_DEPTH - 2, w);
		send_word(w);
		entry_letters(DICT_DEPTH - 1, w);
		send_word(w);
		w.push_back(CHAR_Z);
		send_word(w);
		w = {CHAR_Z, CHAR_Z};
		foreach (w[i])
			send_request(CMD_TEXT, 0, 0, w[i]);
		send_request(CMD_TEXT, 0, 0, CHAR_A - 1);
		send_request(CMD_TEXT, 0, 0, CHAR_Z);
		send_request(CMD_TEXT, 0, 0, CHAR_Z + 1);
		send_request(CMD_READ, 0, 0, 0);
		send_request(CMD_READ, DICT_DEPTH - 1, 31, 8'hFF);
		send_request(CMD_READ, 5, 0, 0);
		send_request(CMD_NONE, 10'h3FF, 31, 8'hFF);
		send_request(CMD_NONE, 0, 0, 0);
	endtask

	task automatic test_word_count_limits();
		logic [7:0] w[$];
		write_word_count(2047);
		entry_letters(DICT_DEPTH - 1, w);
		send_word(w);
		write_word_count(0);
		w = {CHAR_A, CHAR_A, CHAR_A};
		send_word(w);
		write_word_count(1);
		send_word(w);
		w = {CHAR_A, CHAR_A, 8'(CHAR_A + 1)};
		send_word(w);
	endtask

	task automatic test_random_traffic(input int wc, input int items);
		logic [7:0] w[$];
		int sent;
		int pick;
		int span;
		int len;
		write_word_count(wc);
		span = (word_count_reg > DICT_DEPTH) ? DICT_DEPTH : word_count_reg;
		sent = 0;
		while (sent < items) begin
			if ($urandom_range(0, 9) == 0)
				no_gaps = ~no_gaps;
			pick = $urandom_range(0, 99);
			w = {};
			if (pick < 55 && span > 0) begin
				entry_letters($urandom_range(0, span - 1), w);
				if (pick < 8 && w.size() > 0)
					w[$urandom_range(0, w.size() - 1)] = 8'($urandom_range(CHAR_A, CHAR_Z));
				send_word(w);
				sent += w.size() + 1;
			end else if (pick < 70) begin
				len = $urandom_range(1, 6);
				repeat (len) w.push_back(8'($urandom_range(CHAR_A, CHAR_Z)));
				send_word(w);
				sent += len + 1;
			end else if (pick < 75) begin
				len = $urandom_range(MAX_WORD_LEN - 2, MAX_WORD_LEN + 8);
				repeat (len) w.push_back(8'($urandom_range(CHAR_A, CHAR_Z)));
				send_word(w);
				sent += len + 1;
			end else if (pick < 85) begin
				send_request(CMD_READ, $urandom_range(0, 1023), $urandom_range(0, 31),
					$urandom_range(0, 255));
				sent++;
			end else if (pick < 90) begin
				send_request(CMD_NONE, $urandom_range(0, 1023), $urandom_range(0, 31),
					$urandom_range(0, 255));
				sent++;
			end else if (pick < 95) begin
				send_request(CMD_TEXT, $urandom_range(0, 1023), $urandom_range(0, 31),
					random_separator());
				sent++;
			end else begin
				len = $urandom_range(1, 8);
				repeat (len)
					w.push_back(8'(($urandom_range(0, 7) == 0) ? $urandom_range(1, 255)
						: $urandom_range(CHAR_A, CHAR_Z)));
				load_entry($urandom_range(0, DICT_DEPTH - 1), w);
				sent += len + 1;
			end
		end
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				report_mismatch("unexpected result", 1, 0);
			end else begin
				want = pending_results.pop_front();
				if (result.result_kind != want.result_kind)
					report_mismatch("result_kind", result.result_kind, want.result_kind);
				if (result.found_index != want.found_index)
					report_mismatch("found_index", result.found_index, want.found_index);
				if (result.hit_count != want.hit_count)
					report_mismatch("hit_count", result.hit_count, want.hit_count);
			end
		end
	end

	initial begin
		for (int i = 0; i < DICT_DEPTH; i++)
			entry_counts[i] = '0;
		word_len = 0;
		word_overlong = 1'b0;
		word_count_reg = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_dictionary_load();
		test_directed_words();
		test_word_count_limits();
		test_random_traffic(DICT_DEPTH, 300);
		test_random_traffic(2047, 250);
		test_random_traffic(37, 250);
		test_random_traffic(1, 150);
		test_random_traffic(0, 100);
		test_random_traffic(DICT_DEPTH - 1, 300);
		quiesce();
		repeat (400) @(posedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("tb OK");
		else
			$display("tb NOT OK");
		$finish;
	end

	initial begin
		#60ms;
		$display("tb NOT OK");
		$finish;
	end

endmodule
